/* rtl/core/wntc_pkg.sv */
package wntc_pkg;

  // Default sizing
  localparam int unsigned MaxWordsDefault   = 512;
  localparam int unsigned MaxWordLenDefault = 64;
  localparam int unsigned CountBitsDefault  = 16;

  // Fixed field widths of the stream payload
  localparam int unsigned ChW       = 8;
  localparam int unsigned WordCntW  = 16;
  localparam int unsigned NumCntW   = 16;
  localparam int unsigned DistCntW  = 10;
  localparam int unsigned OutDataW  = 48;

  // Scan mode of the character classifier
  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeWord = 2'd1,
    ModeNum  = 2'd2
  } scan_mode_e;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StCmpRead = 7'b0000010,
    StCmpLen  = 7'b0000100,
    StCmpChar = 7'b0001000,
    StCopy    = 7'b0010000,
    StCopyWr  = 7'b0100000,
    StOut     = 7'b1000000
  } seq_state_e;

  function automatic logic is_letter(input logic [ChW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [ChW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

/* rtl/core/wntc_ram.sv */
module wntc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/word_number_token_counter.sv */
// Word and number token counter.
// Slave channel s_axis_*: one character per transaction, tdata = ch,
// tuser = end_of_stream. A zero byte or tuser high closes the stream.
// Master channel m_axis_*: one transaction per stream with the word,
// number and distinct-word counts and the table-full and long-word flags.
// Letters, digits and separators are taken one per cycle while no search or
// copy runs. A transaction that closes a word searches the distinct-word
// store: per stored word its length is read and, on equal length, its
// characters are compared one by one, as every entry lives in a RAM of 8-bit
// characters. A hit leaves the store as it is; a miss copies the word into
// the next free row character by character, or flags a full store.
// s_axis_tready is low throughout. The result is valid the cycle after the
// closing transaction (or after the search) and is held in the output
// register until m_axis_tready; no new character is taken meanwhile.
// Reset clears all counters and the scan mode; the RAMs need no clearing
// since only entries written in the current stream are ever read.
module word_number_token_counter #(
  parameter int unsigned MaxWords   = wntc_pkg::MaxWordsDefault,
  parameter int unsigned MaxWordLen = wntc_pkg::MaxWordLenDefault,
  parameter int unsigned CountBits  = wntc_pkg::CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] word_count, [31:16] number_count, [41:32] distinct_count,
  // [42] table_full, [43] long_word, [47:44] zero
  output logic [wntc_pkg::OutDataW-1:0] m_axis_tdata
);
  import wntc_pkg::*;

  localparam int unsigned LenW  = $clog2(MaxWordLen + 1);
  localparam int unsigned PosW  = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int unsigned DistW = $clog2(MaxWords + 1);
  localparam int unsigned RowW  = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned StoreDepth = MaxWords * MaxWordLen;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};

  seq_state_e state_q, state_d;
  scan_mode_e mode_q, mode_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [DistW-1:0]     dist_q, dist_d;
  logic [CountBits-1:0] words_q, words_d, nums_q, nums_d;
  logic                 full_q, full_d, trunc_q, trunc_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [LenW-1:0]      pos_q, pos_d;
  logic                 eos_pend_q, eos_pend_d;
  logic [ChW-1:0]       pend_ch_q, pend_ch_d;

  // Current-word buffer
  logic            cw_we;
  logic [PosW-1:0] cw_waddr, cw_raddr;
  logic [ChW-1:0]  cw_wdata, cw_rdata;

  // Word store and length store
  logic               ws_we;
  logic [StoreAw-1:0] ws_waddr, ws_raddr;
  logic [ChW-1:0]     ws_rdata;
  logic               sl_we;
  logic [RowW-1:0]    sl_waddr, sl_raddr;
  logic [LenW-1:0]    sl_rdata;

  wntc_ram #(.Width(ChW), .Depth(MaxWordLen)) u_cur_ram (
    .clk_i, .we_i(cw_we), .waddr_i(cw_waddr), .wdata_i(cw_wdata),
    .raddr_i(cw_raddr), .rdata_o(cw_rdata)
  );

  wntc_ram #(.Width(ChW), .Depth(StoreDepth)) u_store_ram (
    .clk_i, .we_i(ws_we), .waddr_i(ws_waddr), .wdata_i(cw_rdata),
    .raddr_i(ws_raddr), .rdata_o(ws_rdata)
  );

  wntc_ram #(.Width(LenW), .Depth(MaxWords)) u_len_ram (
    .clk_i, .we_i(sl_we), .waddr_i(sl_waddr), .wdata_i(len_q),
    .raddr_i(sl_raddr), .rdata_o(sl_rdata)
  );

  logic s_fire, eos_in, letter_in, digit_in;
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign eos_in    = s_axis_tuser || (s_axis_tdata == '0);
  assign letter_in = is_letter(s_axis_tdata);
  assign digit_in  = is_digit(s_axis_tdata);

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);

  logic [WordCntW-1:0] word_out;
  logic [NumCntW-1:0]  num_out;
  logic [DistCntW-1:0] dist_out;
  assign word_out = WordCntW'(words_q);
  assign num_out  = NumCntW'(nums_q);
  assign dist_out = DistCntW'(dist_q);
  assign m_axis_tdata = {4'b0, trunc_q, full_q, dist_out, num_out, word_out};

  logic [StoreAw-1:0] row_base;
  assign row_base = StoreAw'(row_q) * StoreAw'(MaxWordLen);

  logic [LenW-1:0] pos_nxt;
  assign pos_nxt = pos_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    len_d      = len_q;
    dist_d     = dist_q;
    words_d    = words_q;
    nums_d     = nums_q;
    full_d     = full_q;
    trunc_d    = trunc_q;
    row_d      = row_q;
    pos_d      = pos_q;
    eos_pend_d = eos_pend_q;
    pend_ch_d  = pend_ch_q;
    cw_we      = 1'b0;
    cw_waddr   = PosW'(len_q);
    cw_wdata   = s_axis_tdata;
    cw_raddr   = PosW'(pos_q);
    ws_we      = 1'b0;
    ws_waddr   = row_base + StoreAw'(pos_q);
    ws_raddr   = row_base + StoreAw'(pos_q);
    sl_we      = 1'b0;
    sl_waddr   = RowW'(dist_q);
    sl_raddr   = row_q;

    case (state_q)
      StIdle: begin
        if (s_fire) begin
          if ((mode_q == ModeWord) && (eos_in || !letter_in)) begin
            // Word ends: count it, then search the store, or store it if empty
            words_d    = (words_q != CntMax) ? words_q + 1'b1 : words_q;
            eos_pend_d = eos_in;
            pend_ch_d  = s_axis_tdata;
            row_d      = '0;
            pos_d      = '0;
            if (dist_q == '0) begin
              state_d = (dist_q < DistW'(MaxWords)) ? StCopy : StIdle;
            end else begin
              state_d = StCmpRead;
            end
          end else if (eos_in) begin
            if (mode_q == ModeNum) begin
              nums_d = (nums_q != CntMax) ? nums_q + 1'b1 : nums_q;
            end
            state_d = StOut;
          end else if (letter_in) begin
            if (mode_q != ModeWord) begin
              if (mode_q == ModeNum) begin
                nums_d = (nums_q != CntMax) ? nums_q + 1'b1 : nums_q;
              end
              mode_d   = ModeWord;
              len_d    = LenW'(1);
              cw_waddr = '0;
              cw_we    = 1'b1;
            end else if (len_q < LenW'(MaxWordLen)) begin
              cw_we = 1'b1;
              len_d = len_q + 1'b1;
            end else begin
              trunc_d = 1'b1;
            end
          end else if (digit_in) begin
            mode_d = ModeNum;
          end else begin
            if (mode_q == ModeNum) begin
              nums_d = (nums_q != CntMax) ? nums_q + 1'b1 : nums_q;
            end
            mode_d = ModeIdle;
            len_d  = '0;
          end
        end
      end
      StCmpRead: begin
        // Length of row_q is being read
        pos_d   = '0;
        state_d = StCmpLen;
      end
      StCmpLen: begin
        if (sl_rdata == len_q) begin
          state_d = StCmpChar;
        end else begin
          state_d = StCopy;
        end
        if (sl_rdata != len_q) begin
          if (DistW'(row_q) + 1'b1 < dist_q) begin
            row_d   = row_q + 1'b1;
            state_d = StCmpRead;
          end
        end else if (len_q == '0) begin
          state_d = StCopy;
        end
        if ((sl_rdata == len_q) && (len_q == '0)) begin
          state_d = StCopy;
          pos_d   = len_q;
          row_d   = row_q;
        end
        // Miss on the last stored row: store the word, or flag a full store
        if ((sl_rdata != len_q) && !(DistW'(row_q) + 1'b1 < dist_q)) begin
          pos_d = '0;
          state_d = StCopy;
        end
      end
      StCmpChar: begin
        // Both RAMs present character pos_q - 1, read on the previous entry;
        // the first entry issues reads only
        if (pos_q != '0 && cw_rdata != ws_rdata) begin
          pos_d = '0;
          if (DistW'(row_q) + 1'b1 < dist_q) begin
            row_d   = row_q + 1'b1;
            state_d = StCmpRead;
          end else begin
            state_d = StCopy;
          end
        end else if (pos_q == len_q) begin
          // Every character matched: word already stored
          state_d = StCopyWr;
          pos_d   = len_q;
        end else begin
          pos_d = pos_nxt;
        end
      end
      StCopy: begin
        // Copy current word into row dist_q, one character per StCopy/StCopyWr pass
        row_d = RowW'(dist_q);
        if (len_q == '0 || (DistW'(row_q) == dist_q && pos_q == len_q)) begin
          sl_we   = 1'b1;
          dist_d  = dist_q + 1'b1;
          state_d = StCopyWr;
          pos_d   = len_q;
        end else if (DistW'(row_q) == dist_q) begin
          state_d = StCopyWr;
        end else begin
          pos_d = '0;
        end
        if (dist_q >= DistW'(MaxWords)) begin
          full_d  = 1'b1;
          pos_d   = len_q;
          state_d = StCopyWr;
        end
      end
      StCopyWr: begin
        if (pos_q != len_q) begin
          ws_we   = 1'b1;
          pos_d   = pos_nxt;
          state_d = StCopy;
        end else begin
          // Word closed; resume with the character that ended it
          mode_d = ModeIdle;
          len_d  = '0;
          if (eos_pend_q) begin
            state_d = StOut;
          end else begin
            state_d = StIdle;
            if (is_letter(pend_ch_q)) begin
              mode_d = ModeWord;
            end else if (is_digit(pend_ch_q)) begin
              mode_d = ModeNum;
            end
          end
        end
      end
      StOut: begin
        if (m_axis_tready) begin
          state_d = StIdle;
          mode_d  = ModeIdle;
          len_d   = '0;
          dist_d  = '0;
          words_d = '0;
          nums_d  = '0;
          full_d  = 1'b0;
          trunc_d = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      mode_q     <= ModeIdle;
      len_q      <= '0;
      dist_q     <= '0;
      words_q    <= '0;
      nums_q     <= '0;
      full_q     <= 1'b0;
      trunc_q    <= 1'b0;
      row_q      <= '0;
      pos_q      <= '0;
      eos_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      len_q      <= len_d;
      dist_q     <= dist_d;
      words_q    <= words_d;
      nums_q     <= nums_d;
      full_q     <= full_d;
      trunc_q    <= trunc_d;
      row_q      <= row_d;
      pos_q      <= pos_d;
      eos_pend_q <= eos_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ch_q <= pend_ch_d;
  end

endmodule
